// ===== hdl/srgb_to_lightness_core_macros.svh =====
// ----------------------------------------------------------------------------
// srgb_to_lightness_core assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SRGB_TO_LIGHTNESS_CORE_MACROS_SVH
`define SRGB_TO_LIGHTNESS_CORE_MACROS_SVH
`ifndef SYNTHESIS
// condition a implies condition b in the same cycle
`define SLC_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");
// condition a implies condition b later, with the delay given by n
`define SLC_ASSERT_DELAY(lbl, a, n, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> ##n (b)) \
    else $error("assertion failed");
`else
`define SLC_ASSERT_IMPL(lbl, a, b)
`define SLC_ASSERT_DELAY(lbl, a, n, b)
`endif
`endif

// ===== hdl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Constants, tables and types for the sRGB to L* lightness core.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  localparam int LinFracBits  = 16;
  localparam int LinGuardBits = 34;
  localparam int LinRaw       = LinFracBits + LinGuardBits;
  localparam int LinW         = (LinRaw > 50) ? 50 : ((LinRaw < 8) ? 8 : LinRaw);
  localparam int LinEntW      = LinW + 1;
  localparam int SumW         = 64;
  localparam int CntW         = 7;
  localparam int NumThr       = 100;
  localparam int CellThr      = 5;
  localparam int NumCells     = NumThr / CellThr;
  localparam int IncW         = $clog2(CellThr + 1);
  localparam int FrontStages  = 2;
  localparam int Latency      = FrontStages + NumCells;

  localparam int WeightR      = 2126;
  localparam int WeightG      = 7152;
  localparam int WeightB      = 722;
  localparam int LinDiv       = 32946;
  localparam int DenLow       = 24389;
  localparam int DenHigh      = 1560896;
  localparam int BigW         = 512;

  typedef logic [LinEntW-1:0] lin_tab_t [256];
  typedef logic [SumW-1:0] thr_tab_t [NumThr];
  typedef logic [CellThr-1:0][SumW-1:0] thr_grp_t;

  // token handed from cell to cell
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
    logic [CntW-1:0] count;
  } slc_tok_t;

  // integer power on wide words
  function automatic logic [BigW-1:0] big_pow(logic [BigW-1:0] b, int e);
    logic [BigW-1:0] p;
    p = BigW'(1);
    for (int i = 0; i < e; i++) begin
      p = p * b;
    end
    return p;
  endfunction

  // floor(lin(c) * 2^LinW), exact
  function automatic logic [LinEntW-1:0] lin_entry(int c);
    logic [BigW-1:0] d12;
    logic [BigW-1:0] rhs;
    logic [BigW-1:0] lhs;
    logic [BigW-1:0] wide;
    logic [LinEntW:0] lo;
    logic [LinEntW:0] hi;
    logic [LinEntW:0] mid;
    if (c <= 10) begin
      wide = (BigW'(10 * c) << LinW) / LinDiv;
      return wide[LinEntW-1:0];
    end
    d12 = big_pow(BigW'(269025), 12);
    rhs = big_pow(BigW'(1000 * c + 14025), 12) << (5 * LinW);
    lo  = '0;
    hi  = (LinEntW + 1)'(1) << LinW;
    for (int it = 0; it < LinEntW + 2; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        lhs = big_pow(BigW'(mid), 5) * d12;
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return lo[LinEntW-1:0];
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = lin_entry(c);
    end
    return t;
  endfunction

  // smallest sum that reaches lightness k+1
  function automatic thr_tab_t build_thr_tab();
    thr_tab_t t;
    logic [127:0] num;
    logic [127:0] v;
    logic [127:0] q;
    for (int i = 0; i < NumThr; i++) begin
      if (i + 1 <= 8) begin
        num = 128'(27 * (i + 1));
        v   = (num * 128'(10000)) << LinW;
        q   = (v + 128'(DenLow - 1)) / DenLow;
      end else begin
        num = 128'(i + 17) * 128'(i + 17) * 128'(i + 17);
        v   = (num * 128'(10000)) << LinW;
        q   = (v + 128'(DenHigh - 1)) / DenHigh;
      end
      t[i] = q[SumW-1:0];
    end
    return t;
  endfunction

  localparam lin_tab_t LinTab = build_lin_tab();
  localparam thr_tab_t ThrTab = build_thr_tab();

endpackage

`default_nettype wire

// ===== hdl/srgb_to_lightness_core.sv =====
// ----------------------------------------------------------------------------
// srgb_to_lightness_core
// CIE L* lightness (0..100) of an 8-bit-per-channel sRGB pixel.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel transaction is taken on red_i/green_i/blue_i at a rising edge
//   with start high and busy low. busy is always low, so one pixel can be
//   taken on every clock.
//   The result appears on lightness_o with done_o high for one cycle,
//   after the pixel has passed two front stages (table lookup, weighted
//   sum) and a chain of 20 cells, each of which tests the luminance sum
//   against five fixed thresholds and passes it on.
//   Throughput is one pixel per clock; the pipeline holds up to 22 pixels.
//   Results leave in the order pixels came in.
//   Reset clears all valid flags; pixels in flight are dropped.
//   The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "srgb_to_lightness_core_macros.svh"

module srgb_to_lightness_core import slc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output logic [6:0]      lightness_o,
  output logic            done_o
);

  slc_tok_t tok [NumCells+1];
  thr_grp_t thr [NumCells];
  logic     accept;
  logic     white_in;
  logic     black_in;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // linearize and sum
  slc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .tok_o   (tok[0])
  );

  // threshold chain
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    for (genvar j = 0; j < CellThr; j++) begin : g_thr
      assign thr[g][j] = ThrTab[g*CellThr+j];
    end
    slc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .thr_i  (thr[g]),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  assign done_o      = tok[NumCells].valid;
  assign lightness_o = tok[NumCells].count;

  // extreme pixels for the checks
  assign white_in = accept && red_i == 8'hff && green_i == 8'hff && blue_i == 8'hff;
  assign black_in = accept && red_i == 8'h00 && green_i == 8'h00 && blue_i == 8'h00;

  // checks
  `SLC_ASSERT_DELAY(a_latency, accept, Latency, done_o)
  `SLC_ASSERT_IMPL(a_range, done_o, lightness_o <= 7'd100)
  `SLC_ASSERT_DELAY(a_white, white_in, Latency, lightness_o == 7'd100)
  `SLC_ASSERT_DELAY(a_black, black_in, Latency, lightness_o == 7'd0)

endmodule

`default_nettype wire

// ===== hdl/slc_front.sv =====
// ----------------------------------------------------------------------------
// slc_front
// Per-channel linearization lookup and weighted luminance sum, two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_front import slc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output slc_tok_t        tok_o
);

  logic               vld_a_q;
  logic [LinEntW-1:0] lin_r_q, lin_g_q, lin_b_q;
  logic               vld_b_q;
  logic [SumW-1:0]    sum_q, sum_d;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  // table lookup
  always_ff @(posedge clk_i) begin
    lin_r_q <= LinTab[red_i];
    lin_g_q <= LinTab[green_i];
    lin_b_q <= LinTab[blue_i];
  end

  // weighted luminance sum
  assign sum_d = SumW'(WeightR) * SumW'(lin_r_q)
               + SumW'(WeightG) * SumW'(lin_g_q)
               + SumW'(WeightB) * SumW'(lin_b_q);

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign tok_o.valid = vld_b_q;
  assign tok_o.sum   = sum_q;
  assign tok_o.count = '0;

endmodule

`default_nettype wire

// ===== hdl/slc_cell.sv =====
// ----------------------------------------------------------------------------
// slc_cell
// One link of the threshold chain: counts thresholds reached, passes token on.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_cell import slc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire thr_grp_t thr_i,
  input  wire slc_tok_t tok_i,
  output slc_tok_t      tok_o
);

  logic            vld_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IncW-1:0] inc;

  // thresholds reached in this cell
  always_comb begin
    inc = '0;
    for (int j = 0; j < CellThr; j++) begin
      inc = inc + IncW'(tok_i.sum >= thr_i[j]);
    end
    cnt_d = tok_i.count + CntW'(inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= tok_i.sum;
    cnt_q <= cnt_d;
  end

  assign tok_o.valid = vld_q;
  assign tok_o.sum   = sum_q;
  assign tok_o.count = cnt_q;

endmodule

`default_nettype wire

// ===== verif/srgb_to_lightness_core_tb.sv =====
// ----------------------------------------------------------------------------
// srgb_to_lightness_core_tb
// Self-checking bench: drives sRGB pixel transactions, predicts truncated L*
// with an exact fixed-point model and compares every done_o result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srgb_to_lightness_core_tb;

  localparam int FracW     = 50;
  localparam int PipeDepth = 22;
  localparam int MaxCycles = 400000;
  localparam int NumRand   = 1300;
  localparam int NoCheck   = -1;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         lstar;
  } pixel_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic [7:0] red_i = '0;
  logic [7:0] green_i = '0;
  logic [7:0] blue_i = '0;
  logic       busy;
  logic [6:0] lightness_o;
  logic       done_o;

  logic [63:0] lin_lut [256];
  logic [6:0]  lstar_q [$];
  int          typed_q [$];
  int          n_err = 0;
  int          n_sent = 0;
  int          n_seen = 0;
  int          cycles = 0;
  int          idle_pct = 0;

  srgb_to_lightness_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .lightness_o(lightness_o),
    .done_o     (done_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // linearized channel, floor(lin(c) * 2^FracW)
  function automatic logic [63:0] linearize(int c);
    logic [511:0] pw12;
    logic [511:0] rhs;
    logic [511:0] lhs;
    logic [511:0] m5;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    if (c <= 10) return ((64'(10 * c)) << FracW) / 64'd32946;
    pw12 = 1;
    rhs  = 1;
    for (int i = 0; i < 12; i++) begin
      pw12 = pw12 * 512'd269025;
      rhs  = rhs * 512'(1000 * c + 14025);
    end
    rhs = rhs << (5 * FracW);
    lo  = 0;
    hi  = 64'd1 << FracW;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      m5  = 1;
      for (int i = 0; i < 5; i++) m5 = m5 * 512'(mid);
      lhs = m5 * pw12;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // count of lightness thresholds reached by the luminance sum
  function automatic logic [6:0] lightness_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [127:0] lum;
    logic [127:0] num;
    logic [127:0] den;
    int           k;
    lum = 128'(64'd2126 * lin_lut[r] + 64'd7152 * lin_lut[g] + 64'd722 * lin_lut[b]);
    k = 0;
    for (int j = 1; j <= 100; j++) begin
      if (j <= 8) begin
        num = 128'(27 * j);
        den = 128'd24389;
      end else begin
        num = 128'(j + 16) * 128'(j + 16) * 128'(j + 16);
        den = 128'd1560896;
      end
      if (lum * den >= ((num * 128'd10000) << FracW)) k = j;
      else break;
    end
    return 7'(k);
  endfunction

  // record each accepted pixel transaction
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      lstar_q.push_back(lightness_of(red_i, green_i, blue_i));
      n_sent <= n_sent + 1;
    end
  end

  // check each result against the oldest prediction, or the typed value of a directed row where one is given
  always @(posedge clk_i) begin
    logic [6:0] want;
    int         typed;
    if (rst_ni && done_o) begin
      n_seen <= n_seen + 1;
      if (lstar_q.size() == 0) begin
        n_err <= n_err + 1;
        if (n_err < 10) $display("unexpected result %0d", lightness_o);
      end else begin
        want  = lstar_q.pop_front();
        typed = (typed_q.size() > 0) ? typed_q.pop_front() : NoCheck;
        if (typed != NoCheck && typed != int'(want)) want = 7'(typed);
        if (lightness_o !== want) begin
          n_err <= n_err + 1;
          if (n_err < 10) $display("lightness mismatch: exp %0d got %0d", want, lightness_o);
        end
      end
    end
  end

  // one pixel transaction, with optional idle gap before it
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  pixel_row_t dir_tab [] = '{
    '{8'd0,   8'd0,   8'd0,   0},
    '{8'd255, 8'd255, 8'd255, 100},
    '{8'd255, 8'd0,   8'd0,   NoCheck},
    '{8'd0,   8'd255, 8'd0,   NoCheck},
    '{8'd0,   8'd0,   8'd255, NoCheck},
    '{8'd1,   8'd1,   8'd1,   NoCheck},
    '{8'd10,  8'd10,  8'd10,  NoCheck},
    '{8'd11,  8'd11,  8'd11,  NoCheck},
    '{8'd10,  8'd11,  8'd9,   NoCheck},
    '{8'd0,   8'd1,   8'd0,   NoCheck},
    '{8'd254, 8'd254, 8'd254, NoCheck},
    '{8'd128, 8'd128, 8'd128, NoCheck},
    '{8'd255, 8'd255, 8'd0,   NoCheck},
    '{8'd0,   8'd255, 8'd255, NoCheck},
    '{8'd255, 8'd0,   8'd255, NoCheck},
    '{8'd170, 8'd85,  8'd170, NoCheck},
    '{8'd85,  8'd170, 8'd85,  NoCheck},
    '{8'd59,  8'd59,  8'd59,  NoCheck}
  };

  initial begin
    int phase_idle [4];
    phase_idle = '{0, 88, 0, 12};
    for (int c = 0; c < 256; c++) lin_lut[c] = linearize(c);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, typed values where obvious
    foreach (dir_tab[i]) begin
      typed_q.push_back(dir_tab[i].lstar);
      send_pixel(dir_tab[i].r, dir_tab[i].g, dir_tab[i].b);
    end

    // random pixels over idle phases; dark values and bright red/green values weighted in
    for (int i = 0; i < NumRand; i++) begin
      idle_pct = phase_idle[(i * 4) / NumRand];
      if (i % 400 < 40) idle_pct = 0;
      case ($urandom_range(3))
        0: send_pixel(8'($urandom_range(12)), 8'($urandom_range(12)), 8'($urandom_range(12)));
        1: send_pixel(8'($urandom_range(255, 240)), 8'($urandom_range(255, 240)),
                      8'($urandom_range(255)));
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
    start <= 1'b0;

    while (lstar_q.size() > 0) @(posedge clk_i);
    repeat (PipeDepth + 8) @(posedge clk_i);

    $display("pixels sent %0d, results checked %0d, mismatches %0d", n_sent, n_seen, n_err);
    $display("covered black, white, primaries, linear-segment edge and random idle phases");
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
